// ===== src/srs_pkg.sv =====
// ============================================================================
// srs_pkg
// Shared constants, types and operation codes of the sorted range search block.
// ============================================================================
`default_nettype none

package srs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int OUT_IDX_W   = 11;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic signed [CNT_W:0]         t_sidx;
    typedef logic signed [OUT_IDX_W-1:0]   t_out_idx;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

endpackage

`default_nettype wire

// ===== src/srs_if.sv =====
// ============================================================================
// srs_if
// Valid/ready channels of the sorted range search block: command and result.
// ============================================================================
`default_nettype none

interface srs_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    srs_pkg::t_value      element_value;
    srs_pkg::t_value      search_key;

    modport source (output valid, output operation, output element_value,
                    output search_key, input ready);
    modport sink   (input valid, input operation, input element_value,
                    input search_key, output ready);
endinterface

interface srs_out_if;
    logic                 valid;
    logic                 ready;
    logic                 found;
    srs_pkg::t_out_idx    first_index;
    srs_pkg::t_out_idx    last_index;

    modport source (output valid, output found, output first_index,
                    output last_index, input ready);
    modport sink   (input valid, input found, input first_index,
                    input last_index, output ready);
endinterface

`default_nettype wire

// ===== src/sorted_range_search_top.sv =====
// ============================================================================
// sorted_range_search_top
// Ascending table with append/clear and first/last occurrence key search.
// ============================================================================
// The block keeps a table of up to 1024 signed 32-bit values in one memory
// with one write port and one registered read port. A clear or append
// transaction is taken in the idle state, which it does not leave, so the
// block stays ready. A search transaction runs two binary searches, leftmost
// match then rightmost match, on one shared address adder and one signed
// comparator. Each probe passes through the PROBE and CMP states because the
// memory read data is registered: PROBE issues the midpoint address, CMP
// compares and narrows the window. With n filled entries there are at most
// p = ceil(log2(n+1)) probes per binary search. A miss in the first search
// skips the second. The input is not ready while a search runs. The result
// sits in an output register, so the next command is taken while a result
// still waits to be read. When the key is absent, found is 0 and both
// indices are -1. Sortedness of the table is not checked; appends to a full
// table are dropped.
// ============================================================================
`default_nettype none

module sorted_range_search_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srs_in_if.sink     i_in,
    srs_out_if.source  o_out
);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // Table storage, no reset: only entries below the fill count are read.
    srs_pkg::t_value r_mem [srs_pkg::TABLE_DEPTH];
    srs_pkg::t_value r_rdata;

    t_state            r_state, n_state;
    srs_pkg::t_count   r_count, n_count;
    srs_pkg::t_value   r_key,   n_key;
    srs_pkg::t_sidx    r_low,   n_low;
    srs_pkg::t_sidx    r_high,  n_high;
    srs_pkg::t_sidx    r_hit,   n_hit;
    srs_pkg::t_sidx    r_mid,   n_mid;
    srs_pkg::t_sidx    r_first, n_first;
    logic              r_pass,  n_pass;     // 0: leftmost search, 1: rightmost

    logic              r_out_valid, n_out_valid;
    logic              r_found,     n_found;
    srs_pkg::t_out_idx r_out_first, n_out_first;
    srs_pkg::t_out_idx r_out_last,  n_out_last;

    logic              w_accept;
    logic              w_append;
    logic              w_read;
    logic [srs_pkg::CNT_W:0] w_sum;
    srs_pkg::t_sidx    w_mid;
    srs_pkg::t_sidx    w_high0;
    logic              w_open;     // search window not empty

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_found;
    assign o_out.first_index = r_out_first;
    assign o_out.last_index  = r_out_last;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_append = w_accept && (i_in.operation == srs_pkg::OP_APPEND)
                      && (r_count < srs_pkg::CNT_W'(srs_pkg::TABLE_DEPTH));

    // Shared address unit: midpoint of a non-empty window, both bounds >= 0.
    assign w_sum   = r_low + r_high;
    assign w_mid   = {1'b0, w_sum[srs_pkg::CNT_W:1]};
    assign w_open  = (r_low <= r_high);
    assign w_read  = (r_state == ST_PROBE) && w_open;
    assign w_high0 = srs_pkg::t_sidx'({1'b0, r_count}) - srs_pkg::t_sidx'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_low       = r_low;
        n_high      = r_high;
        n_hit       = r_hit;
        n_mid       = r_mid;
        n_first     = r_first;
        n_pass      = r_pass;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.operation)
                        srs_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        srs_pkg::OP_APPEND: begin
                            if (w_append) begin
                                n_count = r_count + srs_pkg::t_count'(1);
                            end
                        end
                        srs_pkg::OP_SEARCH: begin
                            n_key   = i_in.search_key;
                            n_low   = '0;
                            n_high  = w_high0;
                            n_hit   = '1;
                            n_pass  = 1'b0;
                            n_state = ST_PROBE;
                        end
                        default: begin
                            // unused code: no effect
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (w_open) begin
                    n_mid   = w_mid;
                    n_state = ST_CMP;
                end else if (!r_pass) begin
                    if (r_hit[srs_pkg::CNT_W]) begin
                        n_first = '1;
                        n_state = ST_DONE;
                    end else begin
                        // leftmost match found, restart for the rightmost
                        n_first = r_hit;
                        n_low   = '0;
                        n_high  = w_high0;
                        n_hit   = '1;
                        n_pass  = 1'b1;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                if (r_rdata == r_key) begin
                    n_hit = r_mid;
                    if (!r_pass) begin
                        n_high = r_mid - srs_pkg::t_sidx'(1);
                    end else begin
                        n_low  = r_mid + srs_pkg::t_sidx'(1);
                    end
                end else if (r_rdata < r_key) begin
                    n_low  = r_mid + srs_pkg::t_sidx'(1);
                end else begin
                    n_high = r_mid - srs_pkg::t_sidx'(1);
                end
                n_state = ST_PROBE;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = !r_first[srs_pkg::CNT_W];
                    n_out_first = r_first[srs_pkg::OUT_IDX_W-1:0];
                    n_out_last  = r_first[srs_pkg::CNT_W]
                                  ? '1 : r_hit[srs_pkg::OUT_IDX_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_low       <= n_low;
        r_high      <= n_high;
        r_hit       <= n_hit;
        r_mid       <= n_mid;
        r_first     <= n_first;
        r_pass      <= n_pass;
        r_found     <= n_found;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
    end

    // Memory: one write port for appends, one registered read port for probes.
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_mem[r_count[srs_pkg::IDX_W-1:0]] <= i_in.element_value;
        end
        if (w_read) begin
            r_rdata <= r_mem[w_mid[srs_pkg::IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// ===== src/srs_checker.sv =====
// ============================================================================
// srs_checker
// Port-level checks of the sorted range search block, bound to its top level.
// ============================================================================
`default_nettype none

module srs_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [1:0]        i_in_operation,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_out_found,
    input wire srs_pkg::t_out_idx i_out_first,
    input wire srs_pkg::t_out_idx i_out_last
);

    // A pending result is held until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transaction completed");

    // A miss reports -1 on both indices.
    a_miss_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> (&i_out_first) && (&i_out_last))
        else $error("miss without -1 indices");

    // A hit reports an ordered, non-negative index range.
    a_hit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_found |->
            !i_out_first[srs_pkg::OUT_IDX_W-1] && !i_out_last[srs_pkg::OUT_IDX_W-1]
            && ($signed(i_out_last) >= $signed(i_out_first)))
        else $error("hit with bad index range");

    // A search keeps the command channel busy in the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_operation == srs_pkg::OP_SEARCH)
        |=> !i_in_ready)
        else $error("command taken during a search");

endmodule

bind sorted_range_search_top srs_checker u_srs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_found    (o_out.found),
    .i_out_first    (o_out.first_index),
    .i_out_last     (o_out.last_index)
);

`default_nettype wire

// ===== tb/sv/sorted_range_search_monitor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sorted_range_search_monitor
// Watches both channels, tracks the table and checks every search result.
// ============================================================================

module sorted_range_search_monitor (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srs_in_if         i_cmd,
    srs_out_if        i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count,
    output int        o_hit_count
);

    typedef struct packed {
        logic              found;
        srs_pkg::t_out_idx first_index;
        srs_pkg::t_out_idx last_index;
    } t_search_result;

    srs_pkg::t_value key_table [srs_pkg::TABLE_DEPTH];
    int              fill_count;
    t_search_result  result_q [$];
    int              fails;
    int              results;
    int              hits;

    // Binary search over the filled entries; leftmost or rightmost match.
    function automatic int find_edge(srs_pkg::t_value key, bit leftmost);
        int lo;
        int hi;
        int mid;
        int hit;
        lo  = 0;
        hi  = fill_count - 1;
        hit = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_table[mid] == key) begin
                hit = mid;
                if (leftmost) hi = mid - 1;
                else          lo = mid + 1;
            end else if (key_table[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return hit;
    endfunction

    // A miss in the leftmost pass means not found, whatever the right pass says.
    function automatic t_search_result locate_key(srs_pkg::t_value key);
        t_search_result r;
        int             first;
        int             last;
        first = find_edge(key, 1'b1);
        last  = (first >= 0) ? find_edge(key, 1'b0) : -1;
        r.found       = (first >= 0);
        r.first_index = srs_pkg::t_out_idx'(first);
        r.last_index  = srs_pkg::t_out_idx'(last);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_search_result want;
        t_search_result got;
        if (!i_rst_n) begin
            fill_count = 0;
            result_q.delete();
            fails   = 0;
            results = 0;
            hits    = 0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.operation)
                    srs_pkg::OP_CLEAR:  fill_count = 0;
                    srs_pkg::OP_APPEND: begin
                        if (fill_count < srs_pkg::TABLE_DEPTH) begin
                            key_table[fill_count] = i_cmd.element_value;
                            fill_count++;
                        end
                    end
                    srs_pkg::OP_SEARCH:
                        result_q.insert(result_q.size(), locate_key(i_cmd.search_key));
                    default: ;  // unused code: no effect
                endcase
            end

            if (i_res.valid && i_res.ready) begin
                got.found       = i_res.found;
                got.first_index = i_res.first_index;
                got.last_index  = i_res.last_index;
                results++;
                if (got.found === 1'b1) hits++;
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display({"[%0t] result with no search pending:",
                                  " found=%0b first=%0d last=%0d"},
                                 $time, got.found, got.first_index, got.last_index);
                end else begin
                    want = result_q.pop_front();
                    if (got.found !== want.found || got.first_index !== want.first_index
                            || got.last_index !== want.last_index) begin
                        fails++;
                        if (fails <= 10)
                            $display({"[%0t] search mismatch: expected found=%0b first=%0d last=%0d,",
                                      " got found=%0b first=%0d last=%0d"},
                                     $time, want.found, want.first_index, want.last_index,
                                     got.found, got.first_index, got.last_index);
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= result_q.size();
        o_result_count <= results;
        o_hit_count    <= hits;
    end

endmodule

// ===== tb/sv/sorted_range_search_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sorted_range_search_top_test
// Stimulus and verdict for the sorted range search block.
// ============================================================================
// Drives clear, append and search transactions with random gaps on the
// command side and random stalls on the result side. A short directed run hits
// the value extremes, duplicates, an empty table, the unused operation code
// and an unsorted table. Random sessions then build small tables (sorted with
// wide or narrow values, or unsorted) and search for present, adjacent and
// random keys. A last session fills the table past capacity. The monitor
// instance predicts and compares; this module only stimulates and judges.
// ============================================================================

module sorted_range_search_top_test;

    localparam logic [1:0] OP_UNUSED    = 2'd3;  // no name in the package
    localparam int         RANDOM_ITEMS = 40;    // full-table fill adds ~1040
    localparam int         IDLE_LIMIT   = 1500;  // watchdog limit on a quiet stretch
    localparam int         DRAIN_CYCLES = 64;    // settle time after the last result

    logic clk;
    logic rst_n;

    srs_in_if  cmd_ch ();
    srs_out_if res_ch ();

    int fail_count;
    int pending;
    int result_count;
    int hit_count;

    // Stimulus bookkeeping: what was appended, so keys can be aimed at it.
    int table_image [$];
    int items_sent;
    int searches_sent;
    bit tx_steady;      // command side: no gaps while set
    bit rx_steady;      // result side: no stalls while set
    int idle_cycles;

    sorted_range_search_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    sorted_range_search_monitor u_search_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cmd          (cmd_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_hit_count    (hit_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int rnd_word();
        return int'($urandom);
    endfunction

    // Key aimed at the table: a stored value, a neighbor of one, or noise.
    function automatic int pick_key();
        int roll;
        int pick;
        roll = $urandom_range(0, 99);
        if (table_image.size() == 0 || roll < 25) return rnd_word();
        pick = table_image[$urandom_range(0, table_image.size() - 1)];
        if (roll < 75) return pick;
        return (roll < 88) ? pick + 1 : pick - 1;
    endfunction

    // One command transaction. valid is only lowered when a gap follows, so
    // back-to-back transactions never see two assignments in one step.
    task automatic issue(logic [1:0] op, srs_pkg::t_value elem, srs_pkg::t_value key);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.operation     <= op;
        cmd_ch.element_value <= elem;
        cmd_ch.search_key    <= key;
        do @(posedge clk); while (!cmd_ch.ready);

        if (op != OP_UNUSED) items_sent++;
        if (op == srs_pkg::OP_SEARCH) searches_sent++;
        if (op == srs_pkg::OP_CLEAR)
            table_image.delete();
        else if (op == srs_pkg::OP_APPEND && table_image.size() < srs_pkg::TABLE_DEPTH)
            table_image.insert(table_image.size(), elem);
    endtask

    // Random session: mostly a clear, a table of 0..40 values, then searches.
    // Styles: wide sorted values with repeats, narrow sorted values (dense
    // duplicates, sometimes at the ends of the range), or unsorted values.
    task automatic run_session();
        int n_vals;
        int style;
        int base;
        int v;
        int vals [$];
        n_vals = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
        style  = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0:       base = 32'h8000_0000;
            1:       base = 32'h7FFF_FFF0;
            2:       base = -8;
            default: base = rnd_word() >>> 1;
        endcase
        repeat (n_vals) begin
            if (style < 5)
                v = (vals.size() > 0 && $urandom_range(0, 3) == 0)
                    ? vals[$urandom_range(0, vals.size() - 1)] : rnd_word();
            else
                v = base + $urandom_range(0, 15);
            vals.insert(vals.size(), v);
        end
        if (style != 9) vals.sort();

        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);

        // Skipping the clear now and then lets the table grow across sessions.
        if ($urandom_range(0, 9) != 0) issue(srs_pkg::OP_CLEAR, rnd_word(), rnd_word());
        foreach (vals[i]) begin
            issue(srs_pkg::OP_APPEND, vals[i], rnd_word());
            // search a partly built table, and throw in the odd unused code
            if ($urandom_range(0, 9) == 0) issue(srs_pkg::OP_SEARCH, rnd_word(), pick_key());
            if ($urandom_range(0, 19) == 0) issue(OP_UNUSED, rnd_word(), rnd_word());
        end
        repeat ($urandom_range(2, 10)) issue(srs_pkg::OP_SEARCH, rnd_word(), pick_key());
    endtask

    // Result side: per transaction ready is held low for a random stall, unless rx_steady is set, then raised.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("** sorted_range_search_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int v;
        int goal;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.operation     <= srs_pkg::OP_CLEAR;
        cmd_ch.element_value <= '0;
        cmd_ch.search_key    <= '0;
        rst_n                <= 1'b0;
        items_sent    = 0;
        searches_sent = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Empty table: nothing can be found.
        issue(srs_pkg::OP_SEARCH, rnd_word(), 0);
        // Unused operation code must leave everything untouched.
        issue(OP_UNUSED, rnd_word(), rnd_word());
        // Extremes with duplicates: MIN MIN -1 0 0 0 7 MAX MAX
        issue(srs_pkg::OP_APPEND, 32'h8000_0000, rnd_word());
        issue(srs_pkg::OP_APPEND, 32'h8000_0000, rnd_word());
        issue(srs_pkg::OP_APPEND, -1, rnd_word());
        issue(srs_pkg::OP_APPEND, 0, rnd_word());
        issue(srs_pkg::OP_APPEND, 0, rnd_word());
        issue(srs_pkg::OP_APPEND, 0, rnd_word());
        issue(srs_pkg::OP_APPEND, 7, rnd_word());
        issue(srs_pkg::OP_APPEND, 32'h7FFF_FFFF, rnd_word());
        issue(srs_pkg::OP_APPEND, 32'h7FFF_FFFF, rnd_word());
        issue(srs_pkg::OP_SEARCH, rnd_word(), 32'h8000_0000);  // first two slots
        issue(srs_pkg::OP_SEARCH, rnd_word(), -1);
        issue(srs_pkg::OP_SEARCH, rnd_word(), 0);              // run of three
        issue(srs_pkg::OP_SEARCH, rnd_word(), 7);
        issue(srs_pkg::OP_SEARCH, rnd_word(), 32'h7FFF_FFFF);  // last two slots
        issue(srs_pkg::OP_SEARCH, rnd_word(), 1);              // miss between entries
        issue(srs_pkg::OP_SEARCH, rnd_word(), -2);             // miss between entries
        // After a clear the old contents must be gone.
        issue(srs_pkg::OP_CLEAR, rnd_word(), rnd_word());
        issue(srs_pkg::OP_SEARCH, rnd_word(), 0);
        // Unsorted table 5 1 9: 9 is found, 5 is present but missed.
        issue(srs_pkg::OP_APPEND, 5, rnd_word());
        issue(srs_pkg::OP_APPEND, 1, rnd_word());
        issue(srs_pkg::OP_APPEND, 9, rnd_word());
        issue(srs_pkg::OP_SEARCH, rnd_word(), 9);
        issue(srs_pkg::OP_SEARCH, rnd_word(), 5);

        // ---- random sessions ----
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) run_session();

        // ---- full table: last two appends are dropped ----
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        issue(srs_pkg::OP_CLEAR, rnd_word(), rnd_word());
        v = 32'h8000_0000;
        repeat (srs_pkg::TABLE_DEPTH - 1) begin
            issue(srs_pkg::OP_APPEND, v, rnd_word());
            v += $urandom_range(0, 2);
        end
        issue(srs_pkg::OP_APPEND, 32'h7FFF_FFFF, rnd_word());
        issue(srs_pkg::OP_APPEND, v, rnd_word());
        issue(srs_pkg::OP_APPEND, v + 5, rnd_word());
        issue(srs_pkg::OP_SEARCH, rnd_word(), 32'h8000_0000);
        issue(srs_pkg::OP_SEARCH, rnd_word(), 32'h7FFF_FFFF);
        issue(srs_pkg::OP_SEARCH, rnd_word(), v + 5);     // only in a dropped append
        repeat (12) issue(srs_pkg::OP_SEARCH, rnd_word(), pick_key());
        cmd_ch.valid <= 1'b0;

        // Let the monitor see the last transaction, then wait for all results.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands, %0d searches; %0d results checked, %0d hits.",
                 items_sent, searches_sent, result_count, hit_count);
        $display("Tables: extremes, duplicates, empty, unsorted, filled past capacity.");
        if (fail_count == 0) begin
            $display("** sorted_range_search_top: PASSED **");
        end else begin
            $display("%0d failing results", fail_count);
            $display("** sorted_range_search_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/srs_pkg.sv
src/srs_if.sv
src/sorted_range_search_top.sv
src/srs_checker.sv
tb/sv/sorted_range_search_monitor.sv
tb/sv/sorted_range_search_top_test.sv
